// ===== rtl/core/nmf_pkg.sv =====
// Shared constants, payload types and the reciprocal table of the 3x3 mean filter.
`timescale 1ns / 1ps
`default_nettype none

package nmf_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int PIX_W       = 8;
    localparam int CFG_DIM_W   = 11;
    localparam int MODE_W      = 2;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CDIM_W      = COL_W + 1;
    localparam int ROW_W       = $clog2(MAX_ROWS) + 1;
    localparam int SUM_W       = PIX_W + 4;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    // Parity modes; any other code counts every neighbor.
    localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
    localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] mean;
        logic       frame_last;
    } res_out_t;

    typedef struct packed {
        logic [CDIM_W-1:0] cols;
        logic [ROW_W-1:0]  rows;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } win_ctl_t;

    // ceil(2^15 / n); exact floor division for sums up to 9 * 255.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6554;
            4'd6:    r = 16'd5462;
            4'd7:    r = 16'd4682;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3641;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmf_cfg.sv =====
// APB register file holding image size and parity mode.
`timescale 1ns / 1ps
`default_nettype none

module nmf_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nmf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nmf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [nmf_pkg::APB_DATA_W-1:0]  prdata,
    output nmf_pkg::cfg_t                        cfg,
    output logic                                 restart
);
    import nmf_pkg::*;

    logic [CFG_DIM_W-1:0] cols_reg;
    logic [CFG_DIM_W-1:0] rows_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 wr;
    logic [1:0]           idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_DIM_W'(640);
            rows_reg <= CFG_DIM_W'(480);
            mode_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_COLS: cols_reg <= pwdata[CFG_DIM_W-1:0];
                REG_ROWS: rows_reg <= pwdata[CFG_DIM_W-1:0];
                REG_MODE: mode_reg <= pwdata[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    // A size write restarts the frame.
    assign restart = wr && ((idx == REG_COLS) || (idx == REG_ROWS));

    always_comb
    begin
        case (idx)
            REG_COLS: prdata = APB_DATA_W'(cols_reg);
            REG_ROWS: prdata = APB_DATA_W'(rows_reg);
            REG_MODE: prdata = APB_DATA_W'(mode_reg);
            default:  prdata = '0;
        endcase
    end

    // Effective sizes: zero counts as one, large values saturate.
    always_comb
    begin
        if (cols_reg == '0)
            cfg.cols = CDIM_W'(1);
        else if (32'(cols_reg) > MAX_COLS)
            cfg.cols = CDIM_W'(MAX_COLS);
        else
            cfg.cols = CDIM_W'(cols_reg);

        if (rows_reg == '0)
            cfg.rows = ROW_W'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            cfg.rows = ROW_W'(MAX_ROWS);
        else
            cfg.rows = ROW_W'(rows_reg);

        cfg.mode = mode_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/nmf_ctrl.sv =====
// Stream position counters and the first pipeline stage of the filter.
`timescale 1ns / 1ps
`default_nettype none

module nmf_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  nmf_pkg::cfg_t                   cfg,
    input  wire logic                       restart,
    input  wire logic                       accept,
    input  wire logic                       advance,
    input  nmf_pkg::pix_in_t                pix_in,
    output logic [nmf_pkg::COL_W-1:0]       rd_addr,
    output logic                            s1_valid,
    output logic [nmf_pkg::COL_W-1:0]       s1_addr,
    output logic [nmf_pkg::PIX_W-1:0]       s1_pix,
    output nmf_pkg::win_ctl_t               s1_ctl
);
    import nmf_pkg::*;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    win_ctl_t          s1_ctl_reg;
    win_ctl_t          ctl;
    logic [CDIM_W-1:0] in_col_inc;
    logic [CDIM_W-1:0] out_col_inc;
    logic [ROW_W-1:0]  out_row_inc;
    logic              emit;

    assign in_col_inc  = {1'b0, in_col_reg} + CDIM_W'(1);
    assign out_col_inc = {1'b0, out_col_reg} + CDIM_W'(1);
    assign out_row_inc = out_row_reg + ROW_W'(1);

    always_comb
    begin
        emit = (in_row_reg >= ROW_W'(2)) ||
               ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        ctl.emit     = emit && (out_row_reg < cfg.rows);
        ctl.top_ok   = out_row_reg != '0;
        ctl.bot_ok   = out_row_inc < cfg.rows;
        ctl.left_ok  = out_col_reg != '0;
        ctl.right_ok = out_col_inc < cfg.cols;
        ctl.last     = (out_row_inc == cfg.rows) && (out_col_inc == cfg.cols);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (in_col_inc >= cfg.cols)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (ctl.emit)
            begin
                if (out_col_inc >= cfg.cols)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc;
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
                // The frame's final result starts a new frame.
                if (ctl.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (advance)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= in_col_reg;
            s1_pix_reg  <= pix_in.cmd ? '0 : pix_in.pixel;
            s1_ctl_reg  <= ctl;
        end
    end

    assign rd_addr  = in_col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_pix   = s1_pix_reg;
    assign s1_ctl   = s1_ctl_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nmf_line_mem.sv =====
// Two-row line store in one memory, read-modify-write with same-address forwarding.
`timescale 1ns / 1ps
`default_nettype none

module nmf_line_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [nmf_pkg::COL_W-1:0] rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [nmf_pkg::COL_W-1:0] wr_addr,
    input  wire logic [nmf_pkg::PIX_W-1:0] wr_pix,
    output logic      [nmf_pkg::PIX_W-1:0] top,
    output logic      [nmf_pkg::PIX_W-1:0] mid
);
    import nmf_pkg::*;

    // Each entry holds {upper row, middle row} of one column.
    logic [2*PIX_W-1:0] mem_arr [MAX_COLS];
    logic [2*PIX_W-1:0] rdata_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_sel_reg;
    logic [2*PIX_W-1:0] cur;
    logic [2*PIX_W-1:0] wdata;

    assign cur   = fwd_sel_reg ? fwd_data_reg : rdata_reg;
    assign top   = cur[2*PIX_W-1:PIX_W];
    assign mid   = cur[PIX_W-1:0];
    assign wdata = {mid, wr_pix};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_arr[wr_addr] <= wdata;
        if (rd_en)
        begin
            rdata_reg    <= mem_arr[rd_addr];
            fwd_data_reg <= wdata;
        end
    end

    // A read that meets the write-back of the same column takes the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_sel_reg <= 1'b0;
        else if (rd_en)
            fwd_sel_reg <= wr_en && (rd_addr == wr_addr);
    end

endmodule

`default_nettype wire

// ===== rtl/core/nmf_mean.sv =====
// 3x3 window, masked neighborhood sum and reciprocal division.
`timescale 1ns / 1ps
`default_nettype none

module nmf_mean (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       s1_valid,
    input  nmf_pkg::win_ctl_t               s1_ctl,
    input  wire logic [nmf_pkg::PIX_W-1:0]  top,
    input  wire logic [nmf_pkg::PIX_W-1:0]  mid,
    input  wire logic [nmf_pkg::PIX_W-1:0]  pix,
    input  wire logic [nmf_pkg::MODE_W-1:0] mode,
    output logic                            res_valid,
    output nmf_pkg::res_out_t               res
);
    import nmf_pkg::*;

    logic [PIX_W-1:0]         win_reg [9];
    logic                     s2_valid_reg;
    win_ctl_t                 s2_ctl_reg;
    logic                     s3_valid_reg;
    logic [SUM_W-1:0]         s3_sum_reg;
    logic [CNT_W-1:0]         s3_cnt_reg;
    logic                     s3_last_reg;
    logic                     row_ok [3];
    logic                     col_ok [3];
    logic                     take [9];
    logic [SUM_W-1:0]         row_sum [3];
    logic [CNT_W-1:0]         row_cnt [3];
    logic [SUM_W-1:0]         sum;
    logic [CNT_W-1:0]         cnt;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (advance && s1_valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= top;
            win_reg[5] <= mid;
            win_reg[8] <= pix;
        end
    end

    always_comb
    begin
        row_ok[0] = s2_ctl_reg.top_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = s2_ctl_reg.bot_ok;
        col_ok[0] = s2_ctl_reg.left_ok;
        col_ok[1] = 1'b1;
        col_ok[2] = s2_ctl_reg.right_ok;
        for (int k = 0; k < 9; k++)
        begin
            if (mode == PAR_EVEN)
                take[k] = row_ok[k/3] && col_ok[k%3] && !win_reg[k][0];
            else if (mode == PAR_ODD)
                take[k] = row_ok[k/3] && col_ok[k%3] && win_reg[k][0];
            else
                take[k] = row_ok[k/3] && col_ok[k%3];
        end
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = '0;
            row_cnt[r] = '0;
            for (int c = 0; c < 3; c++)
            begin
                if (take[r*3+c])
                begin
                    row_sum[r] = row_sum[r] + SUM_W'(win_reg[r*3+c]);
                    row_cnt[r] = row_cnt[r] + CNT_W'(1);
                end
            end
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];
        cnt = row_cnt[0] + row_cnt[1] + row_cnt[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid && s1_ctl.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
            s2_ctl_reg <= s1_ctl;
        if (advance && s2_valid_reg)
        begin
            s3_sum_reg  <= sum;
            s3_cnt_reg  <= cnt;
            s3_last_reg <= s2_ctl_reg.last;
        end
    end

    // Zero neighbors select a zero reciprocal, so the mean comes out as zero.
    assign prod = {{RECIP_W{1'b0}}, s3_sum_reg} * {{SUM_W{1'b0}}, recip(s3_cnt_reg)};

    assign res_valid      = s3_valid_reg;
    assign res.mean       = prod[RECIP_SHIFT +: PIX_W];
    assign res.frame_last = s3_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/neighborhood_mean_filter_3x3.sv =====
// Top level of the 3x3 neighborhood mean filter: APB registers, pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a raster-order pixel stream on the pix channel and gives,
// for every pixel, the truncated mean of its in-frame 3x3 neighbors on the
// res channel. Both channels move one transfer per cycle when valid is high
// and stall is low. A pixel transfer with cmd set is a drain item; after the
// frame's last pixel the source sends num_cols+1 drains to flush the results.
// Throughput is one item per cycle while the pipeline is not stalled. An item
// passes the line-store read, the window, the sum, the reciprocal multiply
// and the output register; results trail the input stream by one row plus
// one pixel. The line store is one memory with one read and one write port,
// read on transfer and written back when the pipeline next advances, with
// forwarding when both touch the same column. When the receiver stalls a
// waiting result, the whole pipeline holds and pix_stall rises in the same
// cycle. Reset clears the position counters, the window and the pipeline
// valid flags and loads 640x480, all-neighbor mode; the line store needs no
// clearing. Writing num_cols or num_rows restarts the frame. The user must
// write configuration only while the block is idle; it is not enforced.
module neighborhood_mean_filter_3x3 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nmf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [nmf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [nmf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            pix_valid,
    output logic                                 pix_stall,
    input  nmf_pkg::pix_in_t                     pix_data,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output nmf_pkg::res_out_t                    res_data
);
    import nmf_pkg::*;

    cfg_t             cfg;
    logic             restart;
    logic             advance;
    logic             accept;
    logic [COL_W-1:0] rd_addr;
    logic             s1_valid;
    logic [COL_W-1:0] s1_addr;
    logic [PIX_W-1:0] s1_pix;
    win_ctl_t         s1_ctl;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             m_valid;
    res_out_t         m_res;
    logic             res_valid_reg;
    res_out_t         res_data_reg;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance   = !res_valid_reg || !res_stall;
    assign accept    = pix_valid && advance;
    assign pix_stall = !advance;
    assign pready    = 1'b1;

    nmf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .restart (restart)
    );

    nmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .restart  (restart),
        .accept   (accept),
        .advance  (advance),
        .pix_in   (pix_data),
        .rd_addr  (rd_addr),
        .s1_valid (s1_valid),
        .s1_addr  (s1_addr),
        .s1_pix   (s1_pix),
        .s1_ctl   (s1_ctl)
    );

    nmf_line_mem u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (s1_valid && advance),
        .wr_addr (s1_addr),
        .wr_pix  (s1_pix),
        .top     (top),
        .mid     (mid)
    );

    nmf_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .top       (top),
        .mid       (mid),
        .pix       (s1_pix),
        .mode      (cfg.mode),
        .res_valid (m_valid),
        .res       (m_res)
    );

    // Output register; it also closes the path after the multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= m_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && m_valid)
            res_data_reg <= m_res;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

// ===== verif/tb_neighborhood_mean_filter_3x3.sv =====
// Self-checking testbench for the 3x3 neighborhood mean filter.
`timescale 1ns / 1ps

// The testbench streams frames of pixels into the filter and checks every
// result transfer against its own cycle-free model of the filter. The model
// keeps the two previous rows per column, the 3x3 window and the four
// position counters, and is stepped once per accepted pixel transfer. The
// expected results wait in a queue until the result channel delivers them,
// in order.
//
// Stimulus runs in phases. Each phase writes the parity mode and mostly the
// frame size over APB while the filter is idle, queues a run of items for
// the driver, and waits until every expected result has arrived. A short
// directed part covers the extreme pixel values, the degenerate 1x1 frame,
// the parity modes and a frame at the largest width and height. The random
// part sends mostly complete frames of random content, with some frames cut
// short, flushed with pixels instead of drains, or overrun by extra drains.
module tb_neighborhood_mean_filter_3x3;

    import nmf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    // This pause covers the pipeline depth with margin.
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 200;
    localparam int WATCHDOG_LIMIT = 500;

    // Parity mode codes that count every neighbor.
    localparam logic [MODE_W-1:0] PAR_ALL     = 2'd0;
    localparam logic [MODE_W-1:0] PAR_ALL_ALT = 2'd3;

    typedef enum
    {
        SHAPE_FULL,        // pixels, then num_cols+1 drains
        SHAPE_PIXEL_FLUSH, // trailing drains replaced by pixel items
        SHAPE_CUT,         // stream stops partway; next size write restarts
        SHAPE_OVERRUN      // extra drains start the next frame
    } frame_shape_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    pix_in_t               pix_data = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_out_t              res_data;

    neighborhood_mean_filter_3x3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Items waiting to be driven and means waiting to be delivered.
    pix_in_t  pixel_q[$];
    res_out_t pending_means[$];

    // Model state: configuration, line store, window and stream position.
    int unsigned     cfg_cols = 640;
    int unsigned     cfg_rows = 480;
    logic [MODE_W-1:0] cfg_mode = PAR_ALL;
    logic [7:0]      upper_line [MAX_COLS];
    logic [7:0]      middle_line [MAX_COLS];
    logic [7:0]      win [9];
    int unsigned     in_r = 0;
    int unsigned     in_c = 0;
    int unsigned     out_r = 0;
    int unsigned     out_c = 0;

    int  err_cnt = 0;
    int  res_seen = 0;
    int  quiet_cycles = 0;
    int  pix_gap = 0;
    int  res_hold = 0;
    bit  pix_free;
    bit  pix_calm = 1'b0;
    bit  res_calm = 1'b0;

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns, result %0d: %s", $time, res_seen, msg);
        err_cnt++;
    endtask

    function automatic void queue_item(input pix_in_t it);
        pixel_q.insert(pixel_q.size(), it);
    endfunction

    function automatic void queue_expect(input res_out_t r);
        pending_means.insert(pending_means.size(), r);
    endfunction

    // A size register of 0 counts as 1; sizes above the maximum saturate.
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void restart_frame();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_COLS:
            begin
                cfg_cols = val & 32'h7FF;
                restart_frame();
            end
            REG_ROWS:
            begin
                cfg_rows = val & 32'h7FF;
                restart_frame();
            end
            REG_MODE:
                cfg_mode = val[MODE_W-1:0];
            default:
                ;
        endcase
    endfunction

    // Steps the model by one accepted item and queues the mean it produces.
    // The newest item enters the right column of the window; the window's
    // center is the output pixel, one row plus one pixel behind.
    function automatic void advance_filter(input pix_in_t it);
        int unsigned cols;
        int unsigned rows;
        int unsigned c;
        int unsigned sum;
        int unsigned cnt;
        int          k;
        int          nr;
        int          nc;
        logic [7:0]  pv;
        logic [7:0]  top;
        logic [7:0]  mid;
        logic [7:0]  v;
        bit          emit;
        bit          take;
        bit          last;
        res_out_t    r;

        cols = clamp_dim(cfg_cols, MAX_COLS);
        rows = clamp_dim(cfg_rows, MAX_ROWS);
        // A drain counts as a zero pixel where it falls inside the frame.
        pv = it.cmd ? 8'd0 : it.pixel;
        c = (in_c >= cols) ? 0 : in_c;

        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pv;

        for (k = 0; k < 3; k++)
        begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = pv;

        // Nothing comes out until the window has primed one row plus one pixel.
        emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
        in_c++;
        if (in_c >= cols)
        begin
            in_c = 0;
            in_r++;
        end
        if (!emit || out_r >= rows)
            return;

        sum = 0;
        cnt = 0;
        for (k = 0; k < 9; k++)
        begin
            nr = int'(out_r) + k / 3 - 1;
            nc = int'(out_c) + k % 3 - 1;
            v = win[k];
            if (nr >= 0 && nr < int'(rows) && nc >= 0 && nc < int'(cols))
            begin
                case (cfg_mode)
                    PAR_EVEN: take = !v[0];
                    PAR_ODD:  take = v[0];
                    default:  take = 1'b1;
                endcase
                if (take)
                begin
                    sum += 32'(v);
                    cnt++;
                end
            end
        end

        last = (out_r == rows - 1) && (out_c == cols - 1);
        r.mean = (cnt != 0) ? 8'(sum / cnt) : 8'd0;
        r.frame_last = last;
        queue_expect(r);

        out_c++;
        if (out_c >= cols)
        begin
            out_c = 0;
            out_r++;
        end
        // The result flagged as the frame's last starts a new frame.
        if (last)
            restart_frame();
    endfunction

    task automatic check_result(input res_out_t got);
        res_out_t want;
        if (pending_means.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result mean=%0d frame_last=%0b",
                                      got.mean, got.frame_last));
            return;
        end
        want = pending_means.pop_front();
        if (got.mean !== want.mean)
            report_mismatch($sformatf("mean %0d, expected %0d", got.mean, want.mean));
        if (got.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %0b, expected %0b",
                                      got.frame_last, want.frame_last));
        res_seen++;
    endtask

    // Pixel driver. Every accepted transfer steps the model; then a random
    // gap of idle cycles is drawn before the next queued item goes out. In
    // calm stretches the gap is always zero.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix_gap = 0;
        end
        else
        begin
            pix_free = !pix_valid;
            if (pix_valid && !pix_stall)
            begin
                advance_filter(pix_data);
                pix_free = 1'b1;
                if ($urandom_range(0, 63) == 0)
                    pix_calm = !pix_calm;
                pix_gap = pix_calm ? 0 : int'($urandom_range(0, 5));
            end
            if (pix_free)
            begin
                if (pix_gap > 0)
                begin
                    pix_gap--;
                    pix_valid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    pix_data <= pixel_q.pop_front();
                    pix_valid <= 1'b1;
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result transfer is checked, and the
    // receiver then stalls for a random number of cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            res_hold = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                check_result(res_data);
                if ($urandom_range(0, 63) == 0)
                    res_calm = !res_calm;
                res_hold = res_calm ? 0 : int'($urandom_range(0, 5));
            end
            else if (res_hold > 0)
            begin
                res_hold--;
            end
            res_stall <= (res_hold != 0);
        end
    end

    // Cycles since the last transfer on either channel.
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // APB write: setup cycle, then access cycle; pready is always high, so
    // the register takes the value at the edge that ends the access cycle.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, val);
    endtask

    function automatic pix_in_t make_item(input bit drain, input logic [7:0] v);
        pix_in_t it;
        it.cmd = drain;
        it.pixel = v;
        return it;
    endfunction

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Waits until every item is accepted and every mean delivered, then lets
    // the pipeline run dry, since the last items may have caused no result.
    task automatic settle();
        @(negedge clk);
        while (pixel_q.size() != 0 || pix_valid || pending_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Queues one frame of random content in the given shape and returns the
    // number of items queued.
    function automatic int queue_frame(input int unsigned cols, input int unsigned rows,
                                       input frame_shape_t shape);
        int unsigned n_pix;
        int unsigned n_flush;
        int unsigned n_all;
        int unsigned n_swap;
        int unsigned i;

        n_pix = cols * rows;
        n_flush = n_pix + cols + 1;
        n_all = n_flush;
        n_swap = 0;
        case (shape)
            SHAPE_CUT:
                n_all = $urandom_range(1, (rows > 8) ? 4 * cols + 4 : n_pix + cols);
            SHAPE_OVERRUN:
                n_all = n_flush + $urandom_range(1, 3);
            SHAPE_PIXEL_FLUSH:
                n_swap = $urandom_range(1, cols + 1);
            default:
                ;
        endcase
        for (i = 0; i < n_all; i++)
        begin
            if (i < n_pix)
            begin
                // Now and then a drain lands inside the frame.
                if ($urandom_range(0, 15) == 0)
                    queue_item(make_item(1'b1, 8'($urandom_range(0, 255))));
                else
                    queue_item(make_item(1'b0, rand_pixel()));
            end
            else if (i >= n_flush - n_swap && i < n_flush)
            begin
                queue_item(make_item(1'b0, rand_pixel()));
            end
            else
            begin
                queue_item(make_item(1'b1, 8'($urandom_range(0, 255))));
            end
        end
        return n_all;
    endfunction

    initial
    begin
        int           i;
        int           rand_items;
        int unsigned  cols_w;
        int unsigned  rows_w;
        int unsigned  pick;
        frame_shape_t shape;
        frame_shape_t prev_shape;

        for (i = 0; i < MAX_COLS; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++)
            win[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame alternating full scale and zero; the center pixel is a
        // drain carrying 0xFF, which must count as zero.
        apb_write(REG_COLS, 3);
        apb_write(REG_ROWS, 3);
        apb_write(REG_MODE, 32'(PAR_ALL));
        for (i = 0; i < 9; i++)
        begin
            if (i == 4)
                queue_item(make_item(1'b1, 8'hFF));
            else
                queue_item(make_item(1'b0, (i % 2 == 0) ? 8'd255 : 8'd0));
        end
        for (i = 0; i < 4; i++)
            queue_item(make_item(1'b1, 8'h00));
        settle();

        // Zero sizes count as a 1x1 frame; mode 3 counts every neighbor.
        apb_write(REG_COLS, 0);
        apb_write(REG_ROWS, 0);
        apb_write(REG_MODE, 32'(PAR_ALL_ALT));
        queue_item(make_item(1'b0, 8'd255));
        queue_item(make_item(1'b1, 8'h5A));
        queue_item(make_item(1'b1, 8'hA5));
        settle();

        // Even-only mode over a frame of odd values: nothing qualifies.
        apb_write(REG_COLS, 2);
        apb_write(REG_ROWS, 2);
        apb_write(REG_MODE, 32'(PAR_EVEN));
        for (i = 0; i < 4; i++)
            queue_item(make_item(1'b0, 8'(2 * i + 1)));
        for (i = 0; i < 3; i++)
            queue_item(make_item(1'b1, 8'hFF));
        settle();

        // Saturated width and height: one full row plus a few pixels, enough
        // for the first results and the column counter's wrap at the maximum.
        apb_write(REG_COLS, 2047);
        apb_write(REG_ROWS, 2047);
        apb_write(REG_MODE, 32'(PAR_ODD));
        for (i = 0; i < MAX_COLS + 7; i++)
            queue_item(make_item(1'b0, 8'($urandom_range(0, 255))));
        settle();

        // Random frames, mostly small and complete.
        rand_items = 0;
        prev_shape = SHAPE_CUT;
        while (rand_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                shape = SHAPE_FULL;
            else if (pick == 7)
                shape = SHAPE_PIXEL_FLUSH;
            else if (pick == 8)
                shape = SHAPE_CUT;
            else
                shape = SHAPE_OVERRUN;

            // After a frame that ended cleanly, sometimes only the mode
            // changes and the next frame starts without a size write.
            if ((prev_shape == SHAPE_FULL || prev_shape == SHAPE_PIXEL_FLUSH) &&
                $urandom_range(0, 5) == 0)
            begin
                apb_write(REG_MODE, $urandom_range(0, 3));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                cols_w = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 8);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    rows_w = 0;
                else if (pick == 1)
                    rows_w = 1;
                else if (pick == 2)
                    rows_w = MAX_ROWS;
                else
                    rows_w = $urandom_range(2, 6);
                apb_write(REG_COLS, cols_w);
                apb_write(REG_ROWS, rows_w);
                apb_write(REG_MODE, $urandom_range(0, 3));
            end

            // A tall frame is too long to finish; it is always cut short.
            if (clamp_dim(cfg_rows, MAX_ROWS) > 8)
                shape = SHAPE_CUT;
            rand_items += queue_frame(clamp_dim(cfg_cols, MAX_COLS),
                                      clamp_dim(cfg_rows, MAX_ROWS), shape);
            settle();
            prev_shape = shape;
        end

        if (pending_means.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_means.size()));
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/nmf_pkg.sv
rtl/core/nmf_cfg.sv
rtl/core/nmf_ctrl.sv
rtl/core/nmf_line_mem.sv
rtl/core/nmf_mean.sv
rtl/core/neighborhood_mean_filter_3x3.sv
verif/tb_neighborhood_mean_filter_3x3.sv
